// File: rtl/dqae_pkg.sv
// Shared types, constants and helpers for the dotted-quad address extractor.
package dqae_pkg;

  localparam int MAX_STORED_CHARS_DEF = 15;
  localparam int CHAR_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int FIELD_W = 9;   // field value, saturating at FIELD_SAT
  localparam int PROD_W  = 12;  // holds FIELD_SAT * 10 + 9

  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 16'h0030;
  localparam logic [CHAR_W-1:0]  CHAR_NINE = 16'h0039;
  localparam logic [CHAR_W-1:0]  CHAR_DOT  = 16'h002E;

  localparam int MIN_STORED = 7;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 9'd255;
  localparam logic [FIELD_W-1:0] FIELD_SAT = 9'd256;
  localparam logic [1:0]         DOTS_FULL = 2'd3;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_DOT,
    CLS_OTHER
  } char_cls_t;

  // Word held in the input stage.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] character;
  } char_word_t;

  // Outcome of scanning the held word.
  typedef struct packed {
    logic              emit;
    logic [ADDR_W-1:0] address;
  } scan_res_t;

  function automatic char_cls_t classify(input logic [CHAR_W-1:0] c);
    char_cls_t cls;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      cls = CLS_DIGIT;
    end else if (c == CHAR_DOT) begin
      cls = CLS_DOT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// File: rtl/dqae_if.sv
// Valid/ready channel interfaces for characters in and addresses out.
interface dqae_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface dqae_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// File: rtl/dqae_in_reg.sv
// Input register stage: holds one character word until the scanner takes it.
module dqae_in_reg
  import dqae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dqae_char_if.sink   in_ch,
  input  logic        take,
  output char_word_t  word
);

  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r;

  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_r <= in_ch.character;
    end
  end

  assign word.valid     = valid_r;
  assign word.character = char_r;

endmodule

// File: rtl/dqae_scan.sv
// Candidate tracker: per-character state update and address check.
module dqae_scan
  import dqae_pkg::*;
#(
  parameter int MAX_STORED_CHARS = MAX_STORED_CHARS_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  char_word_t word,
  input  logic       fire,
  output scan_res_t  res
);

  localparam int CNT_W = $clog2(MAX_STORED_CHARS + 1);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_STORED_CHARS);
  localparam logic [CNT_W-1:0] MinCnt = CNT_W'(MIN_STORED);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         dot_r, dot_nxt;
  logic [1:0]         sdot_r, sdot_nxt;
  logic               prev_r, prev_nxt;
  logic [FIELD_W-1:0] fval_r [4];
  logic [FIELD_W-1:0] fval_nxt [4];
  logic [3:0]         fdig_r, fdig_nxt;

  char_cls_t          cls;
  logic               room;
  logic [FIELD_W-1:0] cur_val;
  logic [PROD_W-1:0]  prod;
  logic [FIELD_W-1:0] sat_val;
  logic               fields_ok;
  logic               cand_ok;

  assign cls  = classify(word.character);
  assign room = (cnt_r < MaxCnt);

  // value * 10 + digit as two shifts and two adds
  assign cur_val = fval_r[sdot_r];
  assign prod    = (PROD_W'(cur_val) << 3) + (PROD_W'(cur_val) << 1)
                 + PROD_W'(word.character[3:0]);
  assign sat_val = (prod > PROD_W'(FIELD_SAT)) ? FIELD_SAT : prod[FIELD_W-1:0];

  always_comb begin
    fields_ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (!fdig_r[k] || fval_r[k] > FIELD_MAX) begin
        fields_ok = 1'b0;
      end
    end
  end

  assign cand_ok = (dot_r == DOTS_FULL) && prev_r && (cnt_r >= MinCnt)
                 && (sdot_r == DOTS_FULL) && fields_ok;

  always_comb begin
    cnt_nxt  = cnt_r;
    dot_nxt  = dot_r;
    sdot_nxt = sdot_r;
    prev_nxt = prev_r;
    fdig_nxt = fdig_r;
    for (int k = 0; k < 4; k++) begin
      fval_nxt[k] = fval_r[k];
    end
    case (cls)
      CLS_DIGIT: begin
        if (room) begin
          fval_nxt[sdot_r] = sat_val;
          fdig_nxt[sdot_r] = 1'b1;
          cnt_nxt          = cnt_r + 1'b1;
        end
        prev_nxt = 1'b1;
      end
      CLS_DOT: begin
        if (prev_r && dot_r != DOTS_FULL) begin
          if (room) begin
            cnt_nxt  = cnt_r + 1'b1;
            sdot_nxt = sdot_r + 1'b1;
          end
          dot_nxt  = dot_r + 1'b1;
          prev_nxt = 1'b0;
        end else begin
          // drop the candidate, keep the digit mark
          cnt_nxt  = '0;
          dot_nxt  = '0;
          sdot_nxt = '0;
          fdig_nxt = '0;
          for (int k = 0; k < 4; k++) begin
            fval_nxt[k] = '0;
          end
        end
      end
      default: begin
        cnt_nxt  = '0;
        dot_nxt  = '0;
        sdot_nxt = '0;
        fdig_nxt = '0;
        prev_nxt = 1'b0;
        for (int k = 0; k < 4; k++) begin
          fval_nxt[k] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dot_r  <= '0;
      sdot_r <= '0;
      prev_r <= 1'b0;
      fdig_r <= '0;
      for (int k = 0; k < 4; k++) begin
        fval_r[k] <= '0;
      end
    end else if (fire) begin
      cnt_r  <= cnt_nxt;
      dot_r  <= dot_nxt;
      sdot_r <= sdot_nxt;
      prev_r <= prev_nxt;
      fdig_r <= fdig_nxt;
      for (int k = 0; k < 4; k++) begin
        fval_r[k] <= fval_nxt[k];
      end
    end
  end

  assign res.emit    = word.valid && (cls == CLS_OTHER) && cand_ok;
  assign res.address = {fval_r[0][7:0], fval_r[1][7:0], fval_r[2][7:0], fval_r[3][7:0]};

  a_sdot_le_dot: assert property (@(posedge clk) disable iff (!rst_n)
    sdot_r <= dot_r) else $error("kept dots exceed counted dots");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MaxCnt) else $error("stored count beyond limit");

  a_field_sat: assert property (@(posedge clk) disable iff (!rst_n)
    fval_r[0] <= FIELD_SAT && fval_r[1] <= FIELD_SAT
    && fval_r[2] <= FIELD_SAT && fval_r[3] <= FIELD_SAT)
    else $error("field value above saturation");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cls == CLS_OTHER |=> cnt_r == '0 && !prev_r && fdig_r == '0)
    else $error("candidate not cleared after terminator");

endmodule

// File: rtl/dotted_quad_address_extractor_unit.sv
// Top level of the dotted-quad address extractor: stages and result register.
//
// Scans a stream of 16-bit text characters, one word per cycle, and reports
// every dotted-decimal IPv4 address found in it as a 32-bit word with the
// first field in the top byte. Digits and dots build a candidate of which at
// most MAX_STORED_CHARS characters are kept; any other character ends the
// candidate and, if it holds four non-empty fields each at most 255, emits
// its address. Send code 0 after the last character so the final candidate
// gets checked. Throughput is one character per cycle: the whole
// per-character update (compare, multiply by ten as shift-and-add, saturate)
// sits between the input register and the candidate state registers. An
// address passes through the input register and then the result register on
// its way out. The input only stalls when a terminating character that
// completes an address finds the result register full and not being taken.
module dotted_quad_address_extractor_unit
  import dqae_pkg::*;
#(
  parameter int MAX_STORED_CHARS = MAX_STORED_CHARS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  dqae_char_if.sink   in_ch,
  dqae_addr_if.source out_ch
);

  char_word_t        word;
  scan_res_t         res;
  logic              s1_fire;
  logic              out_free;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r;

  // result register is free when empty or drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  // retire the held word unless it carries an address that has nowhere to go
  assign s1_fire  = word.valid && (!res.emit || out_free);

  dqae_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (s1_fire),
    .word  (word)
  );

  dqae_scan #(
    .MAX_STORED_CHARS (MAX_STORED_CHARS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .word  (word),
    .fire  (s1_fire),
    .res   (res)
  );

  // load on emit, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.emit) begin
      out_addr_r <= res.address;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.address = out_addr_r;

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res.emit |=> out_valid_r)
    else $error("emitted address did not reach the result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    word.valid && !s1_fire |-> res.emit && out_valid_r && !out_ch.ready)
    else $error("input stage stalled without a blocked result");

  a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    word.valid && !s1_fire |=> word.valid && $stable(word.character))
    else $error("stalled character word lost or changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !word.valid |-> in_ch.ready)
    else $error("input not ready with an empty input stage");

endmodule

// File: dv/dqae_scan_checker.sv
// Scoreboard for the dotted-quad address extractor: predicts found addresses and checks them.
module dqae_scan_checker
  import dqae_pkg::*;
#(
  parameter int MAX_KEPT = MAX_STORED_CHARS_DEF
)(
  input  logic  clk,
  input  logic  rst_n,
  dqae_char_if  in_ch,
  dqae_addr_if  out_ch,
  output int    errors,
  output int    pending,
  output int    chars_seen,
  output int    addrs_seen
);

  // Candidate being scanned.
  int                 kept;
  logic [1:0]         dots;
  logic [1:0]         kept_dots;
  logic               last_digit;
  logic [FIELD_W-1:0] val [4];
  logic [3:0]         has;

  logic [ADDR_W-1:0]  addr_due [$];

  function automatic void drop_candidate();
    int k;
    kept      = 0;
    dots      = '0;
    kept_dots = '0;
    has       = '0;
    for (k = 0; k < 4; k++) val[k] = '0;
  endfunction

  // Advance the candidate by one character; return 1 when it yields an address.
  function automatic bit scan_char(input logic [CHAR_W-1:0] c,
                                   output logic [ADDR_W-1:0] addr);
    char_cls_t         cls;
    logic [PROD_W-1:0] prod;
    bit                hit;
    int                k;
    hit  = 1'b0;
    addr = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      cls = CLS_DIGIT;
    end else if (c == CHAR_DOT) begin
      cls = CLS_DOT;
    end else begin
      cls = CLS_OTHER;
    end
    case (cls)
      CLS_DIGIT: begin
        if (kept < MAX_KEPT) begin
          prod = PROD_W'(val[kept_dots]) * PROD_W'(4'd10) + PROD_W'(c - CHAR_ZERO);
          val[kept_dots] = (prod > PROD_W'(FIELD_SAT)) ? FIELD_SAT : prod[FIELD_W-1:0];
          has[kept_dots] = 1'b1;
          kept++;
        end
        last_digit = 1'b1;
      end
      CLS_DOT: begin
        if (last_digit && dots < DOTS_FULL) begin
          if (kept < MAX_KEPT) begin
            kept++;
            kept_dots++;
          end
          dots++;
          last_digit = 1'b0;
        end else begin
          // refused dot: the digit mark survives
          drop_candidate();
        end
      end
      default: begin
        hit = (dots == DOTS_FULL) && last_digit && (kept >= MIN_STORED) &&
              (kept_dots == DOTS_FULL);
        for (k = 0; k < 4; k++) begin
          if (!has[k] || val[k] > FIELD_MAX) hit = 1'b0;
        end
        addr = {val[0][7:0], val[1][7:0], val[2][7:0], val[3][7:0]};
        drop_candidate();
        last_digit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    logic [ADDR_W-1:0] want;
    logic [ADDR_W-1:0] found;
    if (!rst_n) begin
      drop_candidate();
      last_digit = 1'b0;
      addr_due.delete();
      errors     = 0;
      chars_seen = 0;
      addrs_seen = 0;
    end else begin
      // check the result side first: it belongs to earlier words
      if (out_ch.valid && out_ch.ready) begin
        if (addr_due.size() == 0) begin
          errors++;
          $display("%0t: address %h arrived with none expected", $time, out_ch.address);
        end else begin
          want = addr_due.pop_front();
          addrs_seen++;
          if (out_ch.address !== want) begin
            errors++;
            $display("%0t: address mismatch, expected %h, got %h",
                     $time, want, out_ch.address);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        chars_seen++;
        if (scan_char(in_ch.character, found)) addr_due.push_back(found);
      end
    end
    pending = addr_due.size();
  end

endmodule

// File: dv/dotted_quad_address_extractor_unit_tb.sv
// Testbench top for the dotted-quad address extractor: clock, reset, stimulus and verdict.
module dotted_quad_address_extractor_unit_tb
  import dqae_pkg::*;
();

  localparam int ITEMS     = 1500;  // characters sent, directed part included, before the random part stops
  localparam int LONG_HOLD = 300;   // cycles of the one long output hold-off
  localparam int HOLD_AT   = 600;   // character count at which that hold-off starts

  logic clk;
  logic rst_n;

  int   errors;
  int   pending;
  int   chars_seen;
  int   addrs_seen;

  // Shared between the sender and the receiver; written only by the sender.
  bit   steady;         // no new random idling on either side while set; the long hold-off still runs
  bit   long_hold_req;  // ask the receiver for its long hold-off

  int   sent;
  logic [CHAR_W-1:0] text [$];  // words waiting to be sent

  dqae_char_if char_bus ();
  dqae_addr_if addr_bus ();

  dotted_quad_address_extractor_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (char_bus),
    .out_ch (addr_bus)
  );

  // Watch both channels, predict and compare; hand the counts back here.
  dqae_scan_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (char_bus),
    .out_ch     (addr_bus),
    .errors     (errors),
    .pending    (pending),
    .chars_seen (chars_seen),
    .addrs_seen (addrs_seen)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run.
  initial begin : watchdog
    #10_000_000;
    $display("%0t: watchdog expired, %0d addresses still due", $time, pending);
    $display("Regression FAIL");
    $finish;
  end

  // Most gaps are short, a few long.
  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Append a string as ASCII words.
  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text.push_back({8'h00, s[i]});
  endfunction

  // Pick a character that ends a candidate. Favor codes right next to the
  // significant ones and codes whose low byte looks like a digit or a dot.
  function automatic logic [CHAR_W-1:0] pick_stop();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 7))
      0: c = 16'h0000;
      1: c = 16'h0020;
      2: c = CHAR_ZERO - 16'd1;
      3: c = CHAR_NINE + 16'd1;
      4: c = {8'($urandom_range(1, 255)), CHAR_ZERO[7:0] + 8'($urandom_range(0, 9))};
      5: c = {8'($urandom_range(1, 255)), CHAR_DOT[7:0]};
      6: c = 16'hFFFF;
      default: begin
        c = 16'($urandom);
        if ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_DOT) c = 16'h002C;
      end
    endcase
    return c;
  endfunction

  // Append one dotted field. Clean fields stay in 0..255; the others also
  // try the saturation edge, long digit runs and empty fields.
  function automatic void add_number(input bit clean);
    int v;
    case ($urandom_range(0, clean ? 9 : 13))
      7:       v = 255;
      8:       v = 0;
      9:       v = $urandom_range(250, 255);
      10:      v = $urandom_range(256, 260);
      11:      v = $urandom_range(261, 99999);
      12:      v = -1;
      default: v = $urandom_range(0, 255);
    endcase
    if (v >= 0) begin
      if ($urandom_range(0, 9) == 0) push_text(clean ? "0" : "000");
      push_text($sformatf("%0d", v));
    end
  endfunction

  // Append a candidate and its end. Broken ones get stray, doubled or
  // trailing dots and the wrong number of fields.
  function automatic void build_run(input bit clean);
    int fields;
    int f;
    fields = clean ? 4 : $urandom_range(1, 5);
    if (!clean && $urandom_range(0, 5) == 0) text.push_back(CHAR_DOT);
    for (f = 0; f < fields; f++) begin
      if (f > 0) begin
        text.push_back(CHAR_DOT);
        if (!clean && $urandom_range(0, 9) == 0) text.push_back(CHAR_DOT);
      end
      add_number(clean);
    end
    if (!clean && $urandom_range(0, 9) == 0) text.push_back(CHAR_DOT);
    text.push_back(pick_stop());
  endfunction

  // Append a short burst of anything.
  function automatic void add_noise();
    int n;
    int k;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0:       text.push_back(CHAR_DOT);
        1:       text.push_back(CHAR_ZERO + 16'($urandom_range(0, 9)));
        default: text.push_back(16'($urandom));
      endcase
    end
  endfunction

  // Offer one word from the falling edge, after an optional gap, and hold
  // it until a rising edge finds ready high.
  task automatic send_word(input logic [CHAR_W-1:0] w);
    int g;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 20) begin
      g = gap_len();
      char_bus.valid     = 1'b0;
      char_bus.character = 16'($urandom);
      repeat (g) @(negedge clk);
    end
    char_bus.valid     = 1'b1;
    char_bus.character = w;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    sent++;
  endtask

  // Receiver: drop ready at random, and once for a long stretch so that the
  // result register stays full and the input backs up behind it.
  initial begin : sink_side
    int  stall;
    bit  long_taken;
    stall      = 0;
    long_taken = 1'b0;
    addr_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_taken) begin
        stall      = LONG_HOLD;
        long_taken = 1'b1;
      end else if (stall == 0 && !steady && $urandom_range(0, 99) < 25) begin
        stall = gap_len();
      end
      if (stall > 0) begin
        addr_bus.ready = 1'b0;
        stall--;
      end else begin
        addr_bus.ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    int clean_left;
    int r;
    char_bus.valid     = 1'b0;
    char_bus.character = '0;
    rst_n         = 1'b0;
    steady        = 1'b0;
    long_hold_req = 1'b0;
    sent          = 0;
    clean_left    = 0;

    // Hold reset, then release it away from the rising edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: smallest and largest addresses, ended by the top code and
    // by the end-of-text code.
    push_text("0.0.0.0");
    text.push_back(16'hFFFF);
    push_text("255.255.255.255");
    text.push_back(16'h0000);
    while (text.size() > 0) send_word(text.pop_front());

    // Random: mostly well-formed addresses, the rest broken candidates and
    // noise. Switch idling off for some runs.
    while (sent < ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);
      if (!long_hold_req && sent >= HOLD_AT) begin
        // keep results coming while the receiver holds off
        long_hold_req = 1'b1;
        clean_left    = 40;
      end
      r = $urandom_range(0, 99);
      if (clean_left > 0) begin
        build_run(1'b1);
        clean_left--;
      end else if (r < 60) begin
        build_run(1'b1);
      end else if (r < 85) begin
        build_run(1'b0);
      end else begin
        add_noise();
      end
      while (text.size() > 0) send_word(text.pop_front());
    end

    // Close the text so a last candidate gets judged, then go idle.
    send_word(16'h0000);
    @(negedge clk);
    char_bus.valid = 1'b0;

    // Drain: wait for every predicted address, then keep watching to
    // catch anything extra.
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Fed %0d characters and checked %0d found addresses,", chars_seen, addrs_seen);
    $display("with random gaps on both sides and one %0d-cycle output hold-off.", LONG_HOLD);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dqae_pkg.sv
rtl/dqae_if.sv
rtl/dqae_in_reg.sv
rtl/dqae_scan.sv
rtl/dotted_quad_address_extractor_unit.sv
dv/dqae_scan_checker.sv
dv/dotted_quad_address_extractor_unit_tb.sv
